FILE: hw/rtl/jsbr_pkg.sv
package jsbr_pkg;

   // Default sizes
   localparam int BUFFER_BITS_DEF = 64;
   localparam int MAX_READ_DEF    = 32;
   localparam int QUEUE_DEPTH     = 2;

   // Field widths
   localparam int BYTE_BITS   = 8;
   localparam int COUNT_BITS  = 6;
   localparam int VALUE_BITS  = 32;
   localparam int AVAIL_BITS  = 7;
   localparam int STATUS_BITS = 3;
   localparam int OP_BITS     = 2;

   // Byte values with meaning in the entropy-coded segment
   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] STUFF_BYTE    = 8'h00;
   localparam logic [7:0] RST_BASE      = 8'hD0;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH  = 2'd0,
      OP_READ  = 2'd1,
      OP_ALIGN = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      BYTE_PLAIN  = 2'd0,
      BYTE_PREFIX = 2'd1,
      BYTE_STUFF  = 2'd2,
      BYTE_RST    = 2'd3
   } byte_class_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_RESTART   = 3'd3,
      ST_MARKER    = 3'd4
   } status_type;

   // Decoded word handed from front to back
   typedef struct packed {
      op_type                 op;
      byte_class_type         cls;
      logic [BYTE_BITS-1:0]   data;
      logic                   scan;
      logic [COUNT_BITS-1:0]  count;
   } cmd_type;

endpackage

FILE: hw/rtl/jsbr_front.sv
module jsbr_front #(
   parameter int MAX_READ = jsbr_pkg::MAX_READ_DEF
) (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,   // raw_byte[7:0], bit_count[13:8], zero
   input  logic [2:0]              req_tuser,   // op[1:0], scan_mode[2]
   output logic                    cmd_valid,
   input  logic                    cmd_ready,
   output jsbr_pkg::cmd_type       cmd
);

   logic [7:0] raw_byte;
   logic [5:0] bit_count;

   assign raw_byte   = req_tdata[7:0];
   assign bit_count  = req_tdata[13:8];
   assign cmd_valid  = req_tvalid;
   assign req_tready = cmd_ready;

   // Decode op, classify the byte, clamp the read length
   always_comb begin
      cmd.op    = jsbr_pkg::op_type'(req_tuser[1:0]);
      cmd.scan  = req_tuser[2];
      cmd.data  = raw_byte;
      cmd.count = (bit_count > 6'(MAX_READ)) ? 6'(MAX_READ) : bit_count;
      priority if (raw_byte == jsbr_pkg::MARKER_PREFIX) begin
         cmd.cls = jsbr_pkg::BYTE_PREFIX;
      end else if (raw_byte == jsbr_pkg::STUFF_BYTE) begin
         cmd.cls = jsbr_pkg::BYTE_STUFF;
      end else if (raw_byte[7:3] == jsbr_pkg::RST_BASE[7:3]) begin
         cmd.cls = jsbr_pkg::BYTE_RST;
      end else begin
         cmd.cls = jsbr_pkg::BYTE_PLAIN;
      end
   end

endmodule

FILE: hw/rtl/jsbr_queue.sv
module jsbr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  jsbr_pkg::cmd_type   in_cmd,
   output logic                out_valid,
   input  logic                out_ready,
   output jsbr_pkg::cmd_type   out_cmd
);

   localparam int DEPTH = jsbr_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   jsbr_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

FILE: hw/rtl/jsbr_back.sv
module jsbr_back #(
   parameter int BUFFER_BITS = jsbr_pkg::BUFFER_BITS_DEF,
   parameter int MAX_READ    = jsbr_pkg::MAX_READ_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  jsbr_pkg::cmd_type   cmd,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata,   // bits_value[31:0], marker_code[39:32],
                                            // next_bit[40], bits_available[47:41]
   output logic [2:0]          rsp_tuser    // status[2:0]
);

   localparam int HW = $clog2(BUFFER_BITS + 1);
   localparam int IW = $clog2(BUFFER_BITS);
   localparam int BB = jsbr_pkg::BYTE_BITS;

   // Bit buffer state
   logic [BUFFER_BITS-1:0] buf_ff, buf_in;
   logic [HW-1:0]          held_ff, held_in;
   logic                   pend_ff, pend_in;

   // Output register
   logic                   rsp_valid_ff;
   logic [31:0]            value_ff, value_in;
   jsbr_pkg::status_type   status_ff, status_in;
   logic [7:0]             marker_ff, marker_in;
   logic                   peek_ff, peek_in;
   logic [HW-1:0]          avail_ff;

   logic                   take;
   logic                   room1, room2;
   logic [1:0]             put_cnt;
   logic [HW-1:0]          cnt_ext;
   logic [HW-1:0]          held_m1;
   logic [BUFFER_BITS-1:0] shifted;
   logic [MAX_READ-1:0]    read_mask;
   logic [MAX_READ-1:0]    read_bits;

   assign take      = cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign cmd_ready = !rsp_valid_ff || rsp_tready;
   assign room1     = (held_ff <= HW'(BUFFER_BITS - BB));
   assign room2     = (held_ff <= HW'(BUFFER_BITS - 2 * BB));
   assign cnt_ext   = HW'(cmd.count);

   // Barrel extraction of the oldest cnt bits
   assign shifted   = buf_ff >> (held_ff - cnt_ext);
   assign read_mask = ~({MAX_READ{1'b1}} << cmd.count);
   assign read_bits = shifted[MAX_READ-1:0] & read_mask;

   // Command execution
   always_comb begin
      pend_in   = pend_ff;
      put_cnt   = 2'd0;
      status_in = jsbr_pkg::ST_OK;
      marker_in = '0;
      value_in  = '0;
      unique case (cmd.op)
         jsbr_pkg::OP_PUSH: begin
            if (!cmd.scan) begin
               // pending FF goes in ahead of the byte
               if (pend_ff ? room2 : room1) begin
                  put_cnt = pend_ff ? 2'd2 : 2'd1;
                  pend_in = 1'b0;
               end else begin
                  status_in = jsbr_pkg::ST_OVERFLOW;
               end
            end else if (!pend_ff) begin
               if (cmd.cls == jsbr_pkg::BYTE_PREFIX) begin
                  pend_in = 1'b1;
               end else if (room1) begin
                  put_cnt = 2'd1;
               end else begin
                  status_in = jsbr_pkg::ST_OVERFLOW;
               end
            end else begin
               unique case (cmd.cls)
                  jsbr_pkg::BYTE_PREFIX: begin
                     // fill byte, one FF stays pending
                  end
                  jsbr_pkg::BYTE_STUFF: begin
                     if (room1) begin
                        put_cnt = 2'd1;
                        pend_in = 1'b0;
                     end else begin
                        status_in = jsbr_pkg::ST_OVERFLOW;
                     end
                  end
                  jsbr_pkg::BYTE_RST: begin
                     pend_in   = 1'b0;
                     status_in = jsbr_pkg::ST_RESTART;
                     marker_in = cmd.data;
                  end
                  jsbr_pkg::BYTE_PLAIN: begin
                     if (room2) begin
                        put_cnt   = 2'd2;
                        pend_in   = 1'b0;
                        status_in = jsbr_pkg::ST_MARKER;
                        marker_in = cmd.data;
                     end else begin
                        status_in = jsbr_pkg::ST_OVERFLOW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         jsbr_pkg::OP_READ: begin
            if (cnt_ext > held_ff) begin
               status_in = jsbr_pkg::ST_UNDERFLOW;
            end else begin
               value_in = 32'(read_bits);
            end
         end
         jsbr_pkg::OP_ALIGN, jsbr_pkg::OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   // Buffer and fill level update
   always_comb begin
      buf_in  = buf_ff;
      held_in = held_ff;
      priority if (put_cnt == 2'd2) begin
         // pending FF then the byte after it (in scan mode, the marker byte)
         buf_in  = {buf_ff[BUFFER_BITS-2*BB-1:0], jsbr_pkg::MARKER_PREFIX,
                    (cmd.cls == jsbr_pkg::BYTE_PLAIN || !cmd.scan) ? cmd.data
                                                                  : jsbr_pkg::MARKER_PREFIX};
         held_in = held_ff + HW'(2 * BB);
      end else if (put_cnt == 2'd1) begin
         buf_in  = {buf_ff[BUFFER_BITS-BB-1:0],
                    (cmd.scan && pend_ff) ? jsbr_pkg::MARKER_PREFIX : cmd.data};
         held_in = held_ff + HW'(BB);
      end else if (cmd.op == jsbr_pkg::OP_READ && status_in == jsbr_pkg::ST_OK) begin
         held_in = held_ff - cnt_ext;
      end else if (cmd.op == jsbr_pkg::OP_ALIGN) begin
         held_in = {held_ff[HW-1:3], 3'b000};
      end else begin
         held_in = held_ff;
      end
   end

   // Peek at the next unread bit after the update
   assign held_m1 = held_in - 1'b1;
   assign peek_in = (held_in != '0) ? buf_in[held_m1[IW-1:0]] : 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            held_ff <= held_in;
            pend_ff <= pend_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         buf_ff    <= buf_in;
         value_ff  <= value_in;
         status_ff <= status_in;
         marker_ff <= marker_in;
         peek_ff   <= peek_in;
         avail_ff  <= held_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {jsbr_pkg::AVAIL_BITS'(avail_ff), peek_ff, marker_ff, value_ff};
   assign rsp_tuser  = status_ff;

   // Fill level never passes the buffer size
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(BUFFER_BITS))
      else $error("fill level above buffer size");

   // A stalled result freezes the buffer state
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(held_ff) && $stable(pend_ff))
      else $error("state moved while result stalled");

   // Align leaves a byte-aligned fill level
   a_align: assert property (@(posedge clock) disable iff (reset)
      take && cmd.op == jsbr_pkg::OP_ALIGN |=> held_ff[2:0] == 3'b000)
      else $error("align left partial byte");

   // Marker code only with a marker status
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != jsbr_pkg::ST_RESTART
         && status_ff != jsbr_pkg::ST_MARKER |-> marker_ff == 8'h00)
      else $error("marker code without marker status");

endmodule

FILE: hw/rtl/jpeg_scan_bit_reader.sv
// Path: a word accepted on req is written into a queue slot; the back end then takes it from
// the queue, executes it and registers the result, which is then presented on rsp.
// Throughput: one word per cycle while neither side stalls; the back end updates the
// bit buffer and does the barrel extraction and peek combinationally for each word.
// Each side may stall on its own: a two-entry queue sits between front and back.
// Reset (synchronous, active high) empties the queue and output register and clears
// the fill level and the pending FF flag.
module jpeg_scan_bit_reader #(
   parameter int BUFFER_BITS = jsbr_pkg::BUFFER_BITS_DEF,
   parameter int MAX_READ    = jsbr_pkg::MAX_READ_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // raw_byte[7:0], bit_count[13:8], zero[15:14]
   input  logic [2:0]  req_tuser,   // op[1:0], scan_mode[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // bits_value[31:0], marker_code[39:32],
                                    // next_bit[40], bits_available[47:41]
   output logic [2:0]  rsp_tuser    // status[2:0]
);

   jsbr_pkg::cmd_type front_cmd;
   jsbr_pkg::cmd_type back_cmd;
   logic              front_valid, front_ready;
   logic              back_valid, back_ready;

   jsbr_front #(
      .MAX_READ (MAX_READ)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   jsbr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   jsbr_back #(
      .BUFFER_BITS (BUFFER_BITS),
      .MAX_READ    (MAX_READ)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
